// ===== sv/hkrd_pkg.sv =====
// Shared constants, types and the usage-code map for the keyboard report differ.
package hkrd_pkg;

  localparam int KEY_SLOTS_DEF = 6;   // stored key slots
  localparam int IN_SLOTS      = 6;   // key slots carried by one report
  localparam int CODE_W        = 8;   // usage code width
  localparam int KEY_W         = 7;   // mapped key code width
  localparam int COUNT_W       = 3;   // key_count width
  localparam int MOD_W         = 8;   // modifier width

  localparam logic [MOD_W-1:0] SHIFT_MASK = 8'h22;

  // Usage codes
  localparam logic [7:0] USE_LETTER_A = 8'h04;
  localparam logic [7:0] USE_LETTER_Z = 8'h1D;
  localparam logic [7:0] USE_DIGIT_1  = 8'h1E;
  localparam logic [7:0] USE_DIGIT_0  = 8'h27;
  localparam logic [7:0] USE_ENTER    = 8'h28;
  localparam logic [7:0] USE_ESCAPE   = 8'h29;
  localparam logic [7:0] USE_BKSP     = 8'h2A;
  localparam logic [7:0] USE_TAB      = 8'h2B;
  localparam logic [7:0] USE_SPACE    = 8'h2C;
  localparam logic [7:0] USE_HOME     = 8'h4A;
  localparam logic [7:0] USE_DELETE   = 8'h4C;
  localparam logic [7:0] USE_END      = 8'h4D;
  localparam logic [7:0] USE_RIGHT    = 8'h4F;
  localparam logic [7:0] USE_LEFT     = 8'h50;
  localparam logic [7:0] USE_DOWN     = 8'h51;
  localparam logic [7:0] USE_UP       = 8'h52;

  // Mapped key codes
  localparam logic [KEY_W-1:0] KEY_NONE   = 7'd0;
  localparam logic [KEY_W-1:0] KEY_HOME   = 7'd2;
  localparam logic [KEY_W-1:0] KEY_END    = 7'd3;
  localparam logic [KEY_W-1:0] KEY_BKSP   = 7'd8;
  localparam logic [KEY_W-1:0] KEY_NEXT   = 7'd9;
  localparam logic [KEY_W-1:0] KEY_ENTER  = 7'd10;
  localparam logic [KEY_W-1:0] KEY_PREV   = 7'd11;
  localparam logic [KEY_W-1:0] KEY_UP     = 7'd17;
  localparam logic [KEY_W-1:0] KEY_DOWN   = 7'd18;
  localparam logic [KEY_W-1:0] KEY_RIGHT  = 7'd19;
  localparam logic [KEY_W-1:0] KEY_LEFT   = 7'd20;
  localparam logic [KEY_W-1:0] KEY_ESCAPE = 7'd27;
  localparam logic [KEY_W-1:0] KEY_SPACE  = 7'h20;
  localparam logic [KEY_W-1:0] KEY_DELETE = 7'd127;
  localparam logic [KEY_W-1:0] CASE_DELTA = 7'h20;
  localparam logic [7:0]       LETTER_OFS = 8'h5D;  // 'a' - USE_LETTER_A

  localparam logic [KEY_W-1:0] DIGIT_PLAIN [10] = '{
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30
  };
  localparam logic [KEY_W-1:0] DIGIT_SHIFT [10] = '{
    7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29
  };

  // One evaluated slot
  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] code;
    logic             pressed;
  } ev_t;

  function automatic logic [KEY_W-1:0] map_usage(input logic shift,
                                                 input logic [CODE_W-1:0] code);
    logic [7:0]       letter;
    logic [7:0]       digit;
    logic [KEY_W-1:0] res;
    letter = code + LETTER_OFS;
    digit  = code - USE_DIGIT_1;
    res    = KEY_NONE;
    case (code)
      USE_ENTER:  res = KEY_ENTER;
      USE_ESCAPE: res = KEY_ESCAPE;
      USE_BKSP:   res = KEY_BKSP;
      USE_DELETE: res = KEY_DELETE;
      USE_TAB:    res = shift ? KEY_PREV : KEY_NEXT;
      USE_UP:     res = KEY_UP;
      USE_DOWN:   res = KEY_DOWN;
      USE_LEFT:   res = KEY_LEFT;
      USE_RIGHT:  res = KEY_RIGHT;
      USE_HOME:   res = KEY_HOME;
      USE_END:    res = KEY_END;
      USE_SPACE:  res = KEY_SPACE;
      default: begin
        if (code >= USE_LETTER_A && code <= USE_LETTER_Z) begin
          res = shift ? (letter[KEY_W-1:0] - CASE_DELTA) : letter[KEY_W-1:0];
        end else if (code >= USE_DIGIT_1 && code <= USE_DIGIT_0) begin
          res = shift ? DIGIT_SHIFT[digit[3:0]] : DIGIT_PLAIN[digit[3:0]];
        end
      end
    endcase
    return res;
  endfunction

endpackage

// ===== sv/hkrd_slot_eval.sv =====
// Shared slot evaluator: membership compare against the other set plus key mapping.
module hkrd_slot_eval #(
  parameter int KEY_SLOTS = hkrd_pkg::KEY_SLOTS_DEF,
  parameter int IDX_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1
) (
  input  logic [hkrd_pkg::CODE_W-1:0] held [KEY_SLOTS],
  input  logic [hkrd_pkg::CODE_W-1:0] cur  [KEY_SLOTS],
  input  logic [IDX_W-1:0]            idx,
  input  logic                        press_phase,
  input  logic [hkrd_pkg::MOD_W-1:0]  modifier,
  output hkrd_pkg::ev_t               ev
);

  logic [hkrd_pkg::CODE_W-1:0] probe;
  logic                        found;
  logic                        shift;
  logic [hkrd_pkg::KEY_W-1:0]  mapped;

  always_comb begin
    // Probe one slot of the own set; search the other set in parallel.
    probe = press_phase ? cur[idx] : held[idx];
    found = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (press_phase) begin
        if (held[j] == probe) found = 1'b1;
      end else begin
        if (cur[j] == probe) found = 1'b1;
      end
    end
    // Releases map without shift.
    shift      = press_phase && ((modifier & hkrd_pkg::SHIFT_MASK) != '0);
    mapped     = hkrd_pkg::map_usage(shift, probe);
    ev.hit     = (probe != '0) && !found && (mapped != hkrd_pkg::KEY_NONE);
    ev.code    = mapped;
    ev.pressed = press_phase;
  end

endmodule

// ===== sv/hid_keyboard_report_diff_top.sv =====
// Top level of the keyboard report differ: stream ports, sequencer and key store.
//
// Usage: one word on the slave stream carries a boot keyboard report
// (s_tuser = 0) or a clear command (s_tuser = 1). A report is compared with
// the keys held from the previous report: a release word goes out on the
// master stream for each held key that is gone (held slot order), then a
// press word for each new key (report slot order). Keys that map to nothing
// give no word. m_tlast marks the final word caused by a report; a report
// that causes nothing, and a clear, give no word at all.
// Timing: the sequencer steps one slot per cycle, unless the receiver stalls
// it, through a single shared evaluator (compare against the other set plus
// key map). A report goes through an accept step, KEY_SLOTS release steps,
// key_count press steps and a closing step; a clear only empties the store.
// s_tready is high only while the sequencer is idle.
// Each found event waits in a pending register until a newer event or the
// close moves it on, so the last one can be tagged; words then move through an
// output register. While both are full and stalled, a slot with an event is held.
// Reset empties the key store, drops any pending word and idles the block.
module hid_keyboard_report_diff_top #(
  parameter int KEY_SLOTS = hkrd_pkg::KEY_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // modifier[7:0], key_count[10:8],
                                 // key_slot_0[18:11] .. key_slot_5[58:51], zero pad
  input  logic        s_tuser,   // kind: 0 report, 1 clear
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // key_code[6:0], zero pad
  output logic        m_tuser,   // pressed
  output logic        m_tlast    // last_event
);

  localparam int IDX_W   = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CMP_W   = IDX_W + hkrd_pkg::COUNT_W;
  localparam int CNT_LIM = (KEY_SLOTS < hkrd_pkg::IN_SLOTS) ? KEY_SLOTS
                                                            : hkrd_pkg::IN_SLOTS;
  localparam int SLOT_LSB = hkrd_pkg::MOD_W + hkrd_pkg::COUNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RELEASE,
    ST_PRESS,
    ST_CLOSE
  } state_t;

  state_t                          state;
  logic [hkrd_pkg::CODE_W-1:0]     held [KEY_SLOTS];
  logic [hkrd_pkg::CODE_W-1:0]     cur  [KEY_SLOTS];
  logic [hkrd_pkg::CODE_W-1:0]     cur_next [KEY_SLOTS];
  logic [hkrd_pkg::MOD_W-1:0]      modifier;
  logic [hkrd_pkg::COUNT_W-1:0]    count;
  logic [hkrd_pkg::COUNT_W-1:0]    count_next;
  logic [IDX_W-1:0]                idx;
  logic                            pend_valid;
  logic [hkrd_pkg::KEY_W-1:0]      pend_code;
  logic                            pend_pressed;

  hkrd_pkg::ev_t                   ev;
  logic                            out_free;
  logic                            stall;
  logic                            last_release;
  logic                            last_press;
  logic                            load_word;
  logic                            load_last;

  // Saturate the report count to the slots that exist.
  always_comb begin
    if (s_tdata[SLOT_LSB-1:hkrd_pkg::MOD_W] > hkrd_pkg::COUNT_W'(CNT_LIM)) begin
      count_next = hkrd_pkg::COUNT_W'(CNT_LIM);
    end else begin
      count_next = s_tdata[SLOT_LSB-1:hkrd_pkg::MOD_W];
    end
  end

  // Report slots past the count, and store slots past the report, read as empty.
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_cur
    if (g < hkrd_pkg::IN_SLOTS) begin : g_in
      assign cur_next[g] = (count_next > hkrd_pkg::COUNT_W'(g))
                         ? s_tdata[SLOT_LSB + hkrd_pkg::CODE_W*g +: hkrd_pkg::CODE_W]
                         : '0;
    end else begin : g_zero
      assign cur_next[g] = '0;
    end
  end

  hkrd_slot_eval #(
    .KEY_SLOTS (KEY_SLOTS),
    .IDX_W     (IDX_W)
  ) u_eval (
    .held        (held),
    .cur         (cur),
    .idx         (idx),
    .press_phase (state == ST_PRESS),
    .modifier    (modifier),
    .ev          (ev)
  );

  assign s_tready     = (state == ST_IDLE);
  assign out_free     = !m_tvalid || m_tready;
  // Hold the slot when a new event must push the pending one out and cannot.
  assign stall        = ev.hit && pend_valid && !out_free;
  assign last_release = (idx == IDX_W'(KEY_SLOTS - 1));
  assign last_press   = (CMP_W'(idx) + CMP_W'(1)) == CMP_W'(count);
  // Move the pending event to the output: pushed out by a newer event, or
  // tagged as the final one when the report closes.
  assign load_last    = (state == ST_CLOSE) && pend_valid && out_free;
  assign load_word    = load_last ||
                        ((state == ST_RELEASE || state == ST_PRESS) &&
                         !stall && ev.hit && pend_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      idx        <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) held[i] <= '0;
    end else begin
      if (load_word) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {1'b0, pend_code};
        m_tuser  <= pend_pressed;
        m_tlast  <= load_last;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) begin
              for (int i = 0; i < KEY_SLOTS; i++) held[i] <= '0;
            end else begin
              modifier <= s_tdata[hkrd_pkg::MOD_W-1:0];
              count    <= count_next;
              cur      <= cur_next;
              idx      <= '0;
              state    <= ST_RELEASE;
            end
          end
        end

        ST_RELEASE, ST_PRESS: begin
          if (!stall) begin
            if (ev.hit) begin
              // Keep the new event pending; the older one goes out above.
              pend_valid   <= 1'b1;
              pend_code    <= ev.code;
              pend_pressed <= ev.pressed;
            end
            if (state == ST_RELEASE) begin
              if (last_release) begin
                idx   <= '0;
                state <= (count == '0) ? ST_CLOSE : ST_PRESS;
              end else begin
                idx <= idx + IDX_W'(1);
              end
            end else begin
              if (last_press) begin
                state <= ST_CLOSE;
              end else begin
                idx <= idx + IDX_W'(1);
              end
            end
          end
        end

        ST_CLOSE: begin
          // Tag the final event and take the report into the store.
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              pend_valid <= 1'b0;
            end
            held  <= cur;
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
